// ===== sv/lbe_pkg.sv =====
// Shared types and constants for the leveled backlog estimator.
// Depends on nothing; lbe_div and the top level import it.
package lbe_pkg;

   localparam int TOT_W = 56;
   localparam int EFF_W = 57;
   localparam int WGT_W = 64;
   localparam int CSR_W = 41;

   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_REMOVE  = 3'd1;
   localparam logic [2:0] KIND_WRITE   = 3'd2;
   localparam logic [2:0] KIND_COMPACT = 3'd3;
   localparam logic [2:0] KIND_EVAL    = 3'd4;

   localparam logic [CSR_W-1:0] MAX_TABLE_RESET = 41'd167772160;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  level;
      logic [47:0] table_bytes;
      logic [47:0] progress_bytes;
   } req_type;

   typedef struct packed {
      logic [62:0] backlog_bytes;
      logic        saturated;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_SQ_GO,
      ST_SQUARE,
      ST_LOGGED,
      ST_WEIGHT,
      ST_EV_START,
      ST_EV_BASE,
      ST_EV_LEVEL,
      ST_EV_DIV,
      ST_EV_MUL,
      ST_EV_NEXT,
      ST_EV_DONE
   } state_type;

endpackage

// ===== sv/lbe_mul.sv =====
// Shared 64x32 multiplier, built from two 32x32 partial products.
// Depends on nothing; used by the estimator sequencer.
module lbe_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [95:0] prod
);
   logic [63:0] a_ff;
   logic [31:0] b_ff;
   logic [63:0] part_ff;
   logic [95:0] prod_ff;
   logic [1:0]  phase_ff;
   logic        done_ff;
   logic [31:0] half_w;
   logic [63:0] pp_w;

   assign half_w = (phase_ff == 2'd1) ? a_ff[31:0] : a_ff[63:32];
   assign pp_w   = 64'(half_w) * 64'(b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            2'd0: begin
               if (start) phase_ff <= 2'd1;
            end
            2'd1: phase_ff <= 2'd2;
            2'd2: begin
               phase_ff <= 2'd0;
               done_ff  <= 1'b1;
            end
            default: phase_ff <= 2'd0;
         endcase
      end
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      part_ff <= pp_w;
      prod_ff <= {32'd0, part_ff} + {pp_w, 32'd0};
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

// ===== sv/lbe_div.sv =====
// Restoring divider for the fan-out ratio, one quotient bit a cycle.
// Depends on lbe_pkg for field widths.
module lbe_div #(
   parameter int FAN_OUT       = 10,
   parameter int LOG_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lbe_pkg::EFF_W-1:0] num,
   input  logic [lbe_pkg::CSR_W-1:0] den,
   output logic                      done,
   output logic [31:0]               ratio
);
   import lbe_pkg::*;

   localparam int NUM_W = EFF_W + LOG_FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [NUM_W-1:0] CAP = NUM_W'(FAN_OUT) << LOG_FRAC_BITS;

   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [CSR_W-1:0] rem_ff;
   logic [CSR_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [CSR_W:0]   rem_sh;
   logic             ge;
   logic [CSR_W:0]   rem_sub;

   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         num_ff <= {num, {LOG_FRAC_BITS{1'b0}}};
         quo_ff <= '0;
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? rem_sub[CSR_W-1:0] : rem_sh[CSR_W-1:0];
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign done  = done_ff;
   assign ratio = (den_ff == '0 || quo_ff >= CAP) ? 32'(CAP) : 32'(quo_ff);
endmodule

// ===== sv/leveled_backlog_estimator.sv =====
// Leveled backlog estimator top level: state, sequencer, result register.
// Depends on lbe_pkg, lbe_mul and lbe_div.
//
//   channel  ports                          beat moves
//   req      req_valid/req_stall/req_data   one add, remove, ongoing or evaluate item
//   rsp      rsp_valid/rsp_stall/rsp_data   one backlog result per evaluate
//   csr      csr_valid/csr_ready/csr_data   new max_table_bytes
//
// Update beats off level 0 are applied in idle. Level-0 updates run log4 on the shared
// multiplier: normalize steps, squaring passes and a weight multiply. Evaluate adds
// at most one log4 and, per level pair column, a divider pass plus a multiply.
// Reset is synchronous and clears all totals; req_stall is high while busy.
module leveled_backlog_estimator #(
   parameter int LEVELS        = 9,
   parameter int FAN_OUT       = 10,
   parameter int LOG_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lbe_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lbe_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lbe_pkg::CSR_W-1:0] csr_data
);
   import lbe_pkg::*;

   localparam int LV_W   = $clog2(LEVELS);
   localparam int BITS_W = LOG_FRAC_BITS + 1;
   localparam int IT_W   = $clog2(LOG_FRAC_BITS + 1);

   function automatic logic [TOT_W-1:0] f_add56(input logic [TOT_W-1:0] a,
                                                input logic [TOT_W-1:0] b);
      logic [TOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOT_W] ? '1 : s[TOT_W-1:0];
   endfunction

   function automatic logic [WGT_W-1:0] f_sat64(input logic [WGT_W-1:0] a,
                                                input logic [WGT_W-1:0] b);
      logic [WGT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WGT_W] ? '1 : s[WGT_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [TOT_W-1:0] level_total_ff [LEVELS];
   logic [TOT_W-1:0] pend_wr_ff [LEVELS];
   logic [TOT_W-1:0] pend_cmp_ff [LEVELS];
   logic [TOT_W-1:0] base_total_ff, base_write_total_ff, base_done_total_ff;
   logic [WGT_W-1:0] base_weight_ff, base_write_weight_ff, base_done_weight_ff;
   logic [CSR_W-1:0] max_table_ff;

   logic [2:0]        kind_ff;
   logic              eval_ff;
   logic [63:0]       x_ff;
   logic [5:0]        e_ff;
   logic [31:0]       m_ff;
   logic [BITS_W-1:0] bits_ff;
   logic [IT_W-1:0]   it_ff;
   logic [31:0]       log_ff;
   logic [63:0]       amt_ff;
   logic [63:0]       acc_ff;
   logic              sat_ff;
   logic [LV_W-1:0]   lvl_ff;
   logic [63:0]       sum_ff;
   logic [EFF_W-1:0]  eff_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic        mul_start, mul_done;
   logic [63:0] mul_a;
   logic [31:0] mul_b;
   logic [95:0] mul_prod;
   logic        div_start, div_done;
   logic [31:0] div_ratio;

   logic              req_accept;
   logic [LV_W-1:0]   in_idx;
   logic              in_valid_lv;
   logic              in_base;
   logic              need_log;
   logic [47:0]       cmp_left;
   logic              mul_hi_nz;
   logic [63:0]       mul_w;
   logic [64:0]       pos_sum;
   logic [63:0]       pos_w;
   logic [64:0]       acc_sum;
   logic [64:0]       neg_sum;
   logic [EFF_W-1:0]  tpos;
   logic [31:0]       sq;
   logic [BITS_W-1:0] bits_new;
   logic [EFF_W-1:0]  lvl_sum;
   logic              lvl_neg;
   logic [EFF_W-1:0]  eff_w;
   logic              lvl_pair;
   logic              rsp_free;

   assign req_accept  = req_valid && !req_stall;
   assign in_idx      = LV_W'(req_data.level);
   assign in_valid_lv = 32'(req_data.level) < LEVELS && req_data.kind <= KIND_COMPACT;
   assign in_base     = in_valid_lv && req_data.level == 4'd0;
   assign cmp_left    = (req_data.table_bytes > req_data.progress_bytes) ?
                        req_data.table_bytes - req_data.progress_bytes : 48'd0;

   always_comb begin
      need_log = 1'b0;
      case (req_data.kind)
         KIND_ADD, KIND_REMOVE: need_log = req_data.table_bytes != '0;
         KIND_WRITE:            need_log = req_data.progress_bytes != '0;
         KIND_COMPACT:          need_log = 1'b1;
         default:               need_log = 1'b0;
      endcase
   end

   assign mul_hi_nz = |mul_prod[95:64];
   assign mul_w     = mul_hi_nz ? '1 : mul_prod[63:0];
   assign pos_sum   = {1'b0, mul_w} + {1'b0, base_done_weight_ff};
   assign pos_w     = pos_sum[64] ? '1 : pos_sum[63:0];
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, mul_prod[63:0]};
   assign neg_sum   = {1'b0, base_weight_ff} + {1'b0, base_write_weight_ff};
   assign tpos      = {1'b0, base_total_ff} + {1'b0, base_write_total_ff};
   assign sq        = mul_prod[61:30];
   assign bits_new  = {bits_ff[BITS_W-2:0], sq[31]};
   assign lvl_sum   = {1'b0, level_total_ff[lvl_ff]} + {1'b0, pend_wr_ff[lvl_ff]};
   assign lvl_neg   = lvl_sum < {1'b0, pend_cmp_ff[lvl_ff]};
   assign eff_w     = lvl_neg ? '0 : lvl_sum - {1'b0, pend_cmp_ff[lvl_ff]};
   assign lvl_pair  = lvl_ff != '0 && lvl_ff != LV_W'(LEVELS - 1);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      mul_a     = amt_ff;
      mul_b     = log_ff;
      div_start = 1'b0;
      req_stall = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.kind == KIND_EVAL) state_in = ST_EV_START;
               else if (in_base && need_log)   state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (x_ff == '0)   state_in = ST_LOGGED;
            else if (x_ff[63]) state_in = ST_SQ_GO;
         end
         ST_SQ_GO: begin
            mul_start = 1'b1;
            mul_a     = {32'd0, m_ff};
            mul_b     = m_ff;
            state_in  = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (mul_done) state_in = (it_ff == IT_W'(LOG_FRAC_BITS)) ? ST_LOGGED : ST_SQ_GO;
         end
         ST_LOGGED: begin
            mul_start = 1'b1;
            state_in  = eval_ff ? ST_EV_BASE : ST_WEIGHT;
         end
         ST_WEIGHT: begin
            if (mul_done) state_in = ST_IDLE;
         end
         ST_EV_START: begin
            state_in = (tpos > {1'b0, base_done_total_ff}) ? ST_NORM : ST_EV_LEVEL;
         end
         ST_EV_BASE: begin
            if (mul_done) state_in = ST_EV_LEVEL;
         end
         ST_EV_LEVEL: begin
            div_start = lvl_pair;
            state_in  = lvl_pair ? ST_EV_DIV : ST_EV_NEXT;
         end
         ST_EV_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_a     = sum_ff;
               mul_b     = div_ratio;
               state_in  = ST_EV_MUL;
            end
         end
         ST_EV_MUL: begin
            if (mul_done) state_in = ST_EV_NEXT;
         end
         ST_EV_NEXT: begin
            state_in = (lvl_ff == LV_W'(LEVELS - 1)) ? ST_EV_DONE : ST_EV_LEVEL;
         end
         ST_EV_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            level_total_ff[i] <= '0;
            pend_wr_ff[i]     <= '0;
            pend_cmp_ff[i]    <= '0;
         end
         base_total_ff        <= '0;
         base_write_total_ff  <= '0;
         base_done_total_ff   <= '0;
         base_weight_ff       <= '0;
         base_write_weight_ff <= '0;
         base_done_weight_ff  <= '0;
         max_table_ff         <= MAX_TABLE_RESET;
      end else begin
         if (csr_valid) max_table_ff <= csr_data;
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && in_valid_lv) begin
                  case (req_data.kind)
                     KIND_ADD: begin
                        level_total_ff[in_idx] <= f_add56(level_total_ff[in_idx],
                                                          TOT_W'(req_data.table_bytes));
                        if (in_base && need_log)
                           base_total_ff <= f_add56(base_total_ff,
                                                    TOT_W'(req_data.table_bytes));
                     end
                     KIND_REMOVE: begin
                        level_total_ff[in_idx] <=
                           (level_total_ff[in_idx] > TOT_W'(req_data.table_bytes)) ?
                           level_total_ff[in_idx] - TOT_W'(req_data.table_bytes) : '0;
                        if (in_base && need_log)
                           base_total_ff <= (base_total_ff > TOT_W'(req_data.table_bytes)) ?
                              base_total_ff - TOT_W'(req_data.table_bytes) : '0;
                     end
                     KIND_WRITE: begin
                        pend_wr_ff[in_idx] <= f_add56(pend_wr_ff[in_idx],
                                                      TOT_W'(req_data.progress_bytes));
                        if (in_base && need_log)
                           base_write_total_ff <= f_add56(base_write_total_ff,
                                                          TOT_W'(req_data.progress_bytes));
                     end
                     default: begin
                        pend_cmp_ff[in_idx] <= f_add56(pend_cmp_ff[in_idx],
                                                       TOT_W'(req_data.progress_bytes));
                        if (in_base)
                           base_done_total_ff <= f_add56(base_done_total_ff,
                                                         TOT_W'(req_data.progress_bytes));
                     end
                  endcase
               end
            end
            ST_WEIGHT: begin
               if (mul_done) begin
                  case (kind_ff)
                     KIND_ADD:    base_weight_ff <= f_sat64(base_weight_ff, mul_w);
                     KIND_REMOVE: base_weight_ff <= (base_weight_ff > mul_w) ?
                                                    base_weight_ff - mul_w : '0;
                     KIND_WRITE:  base_write_weight_ff <= f_sat64(base_write_weight_ff, mul_w);
                     default:     base_done_weight_ff <= f_sat64(base_done_weight_ff, mul_w);
                  endcase
               end
            end
            ST_EV_DONE: begin
               if (rsp_free) begin
                  for (int i = 0; i < LEVELS; i++) begin
                     pend_wr_ff[i]  <= '0;
                     pend_cmp_ff[i] <= '0;
                  end
                  base_write_total_ff  <= '0;
                  base_write_weight_ff <= '0;
                  base_done_total_ff   <= '0;
                  base_done_weight_ff  <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            kind_ff <= req_data.kind;
            eval_ff <= req_data.kind == KIND_EVAL;
            e_ff    <= 6'd63;
            case (req_data.kind)
               KIND_WRITE: begin
                  x_ff   <= 64'(req_data.progress_bytes);
                  amt_ff <= 64'(req_data.progress_bytes);
               end
               KIND_COMPACT: begin
                  x_ff   <= 64'(cmp_left);
                  amt_ff <= 64'(req_data.progress_bytes);
               end
               default: begin
                  x_ff   <= 64'(req_data.table_bytes);
                  amt_ff <= 64'(req_data.table_bytes);
               end
            endcase
         end
         ST_NORM: begin
            if (x_ff == '0) begin
               log_ff <= '0;
            end else if (x_ff[63:56] == '0) begin
               x_ff <= x_ff << 8;
               e_ff <= e_ff - 6'd8;
            end else if (!x_ff[63]) begin
               x_ff <= x_ff << 1;
               e_ff <= e_ff - 6'd1;
            end else begin
               m_ff    <= {1'b0, x_ff[63:33]};
               bits_ff <= '0;
               it_ff   <= '0;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               m_ff    <= sq[31] ? {1'b0, sq[31:1]} : sq;
               bits_ff <= bits_new;
               it_ff   <= it_ff + IT_W'(1);
               log_ff  <= 32'({e_ff, bits_new} >> 1);
            end
         end
         ST_EV_START: begin
            acc_ff <= '0;
            lvl_ff <= '0;
            if (tpos > {1'b0, base_done_total_ff}) begin
               amt_ff <= 64'(tpos - {1'b0, base_done_total_ff});
               x_ff   <= 64'(tpos - {1'b0, base_done_total_ff});
               e_ff   <= 6'd63;
               sum_ff <= neg_sum[64] ? '1 : neg_sum[63:0];
               sat_ff <= neg_sum[64];
            end else begin
               sum_ff <= '0;
               sat_ff <= tpos < {1'b0, base_done_total_ff};
            end
         end
         ST_EV_BASE: begin
            if (mul_done) begin
               acc_ff <= (pos_w > sum_ff) ? pos_w - sum_ff : '0;
               sat_ff <= sat_ff | mul_hi_nz | pos_sum[64];
               sum_ff <= '0;
            end
         end
         ST_EV_LEVEL: begin
            eff_ff <= eff_w;
            if (lvl_neg) sat_ff <= 1'b1;
         end
         ST_EV_MUL: begin
            if (mul_done) begin
               if (mul_hi_nz || acc_sum[64]) begin
                  acc_ff <= '1;
                  sat_ff <= 1'b1;
               end else begin
                  acc_ff <= acc_sum[63:0];
               end
            end
         end
         ST_EV_NEXT: begin
            sum_ff <= sum_ff + 64'(eff_ff);
            lvl_ff <= lvl_ff + LV_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EV_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_EV_DONE && rsp_free) begin
         rsp_data_ff.backlog_bytes <= 63'(acc_ff >> LOG_FRAC_BITS);
         rsp_data_ff.saturated     <= sat_ff;
      end
   end

   lbe_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   lbe_div #(
      .FAN_OUT       (FAN_OUT),
      .LOG_FRAC_BITS (LOG_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (eff_w),
      .den   (max_table_ff),
      .done  (div_done),
      .ratio (div_ratio)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
